/* sv/dafx_pkg.sv */
package dafx_pkg;

    localparam int COORD_BITS   = 24;
    localparam int ANGLE_BITS   = 16;
    localparam int LIMB_BITS    = 16;  // multiplier partial product limb
    localparam int SQ_BITS      = 64;  // squared bond length, normalized
    localparam int ROOT_BITS    = 32;
    localparam int OP_BITS      = 30;  // CORDIC operand magnitude
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_BITS  = 34;
    localparam int SHIFT_BITS   = 5;   // pair shift count of the length normalizer

    // atan(2^-i) in units of pi / 2^31
    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ba_x;
        logic signed [COORD_BITS-1:0] ba_y;
        logic signed [COORD_BITS-1:0] ba_z;
        logic signed [COORD_BITS-1:0] bc_x;
        logic signed [COORD_BITS-1:0] bc_y;
        logic signed [COORD_BITS-1:0] bc_z;
        logic signed [COORD_BITS-1:0] cd_x;
        logic signed [COORD_BITS-1:0] cd_y;
        logic signed [COORD_BITS-1:0] cd_z;
    } t_item;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] angle;
        logic                         angle_valid;
    } t_result;

endpackage

/* sv/dihedral_angle_fixed_core.sv */
// Pipeline: an item taken at a start edge comes out on o_result with o_strobe after passing
// through the 32-cell square root chain, the 30-cell CORDIC chain, 7 operand normalizing
// stages and 13 product and normalizing stages.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls and
// the receiver cannot hold results off.
// Reset (synchronous, active low) clears the valid pipeline; items in flight are dropped.
module dihedral_angle_fixed_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  dafx_pkg::t_item   i_item,
    output logic              o_strobe,
    output dafx_pkg::t_result o_result
);

    localparam int C    = dafx_pkg::COORD_BITS;
    localparam int AB   = dafx_pkg::ANGLE_BITS;
    localparam int SW   = dafx_pkg::SQ_BITS;
    localparam int RB   = dafx_pkg::ROOT_BITS;
    localparam int KB   = dafx_pkg::SHIFT_BITS;
    localparam int CB   = dafx_pkg::CORDIC_BITS;
    localparam int NCS  = dafx_pkg::CORDIC_STEPS;
    localparam int WN   = 2*C + 2;          // normal component
    localparam int WXD  = 2*WN + 2;         // n1 . n2
    localparam int WTD  = C + WN + 2;       // ba . n2
    localparam int WX   = WXD + (1 << KB) - 1;
    localparam int WY   = RB + 1 + WTD;
    localparam int WM   = (WX > WY) ? WX : WY;
    localparam int NJ   = $clog2(WM - dafx_pkg::OP_BITS + 1);
    localparam int NRM  = 5;                // length normalizer stages
    localparam int LAT  = 74 + NJ;          // edge at which the final CORDIC stage holds the item

    assign busy = 1'b0;

    // ---------------- stage 1: cross and square products
    logic signed [C-1:0]   ba [3];
    logic signed [C-1:0]   bc [3];
    logic signed [C-1:0]   cd [3];
    logic signed [C:0]     nb [3];
    logic signed [2*C:0]   r_p1a [3];
    logic signed [2*C:0]   r_p1b [3];
    logic signed [2*C:0]   r_p2a [3];
    logic signed [2*C:0]   r_p2b [3];
    logic signed [2*C-1:0] r_sqp [3];
    logic signed [C-1:0]   r_ba1 [3];

    assign ba[0] = i_item.ba_x;
    assign ba[1] = i_item.ba_y;
    assign ba[2] = i_item.ba_z;
    assign bc[0] = i_item.bc_x;
    assign bc[1] = i_item.bc_y;
    assign bc[2] = i_item.bc_z;
    assign cd[0] = i_item.cd_x;
    assign cd[1] = i_item.cd_y;
    assign cd[2] = i_item.cd_z;

    for (genvar g = 0; g < 3; g++) begin : g_cross
        localparam int I1 = (g + 1) % 3;
        localparam int I2 = (g + 2) % 3;
        assign nb[g] = -((C+1)'(ba[g]));
        always_ff @(posedge i_clk) begin
            r_p1a[g] <= (2*C+1)'(nb[I1]) * (2*C+1)'(bc[I2]);
            r_p1b[g] <= (2*C+1)'(nb[I2]) * (2*C+1)'(bc[I1]);
            r_p2a[g] <= (2*C+1)'(bc[I1]) * (2*C+1)'(cd[I2]);
            r_p2b[g] <= (2*C+1)'(bc[I2]) * (2*C+1)'(cd[I1]);
            r_sqp[g] <= (2*C)'(bc[g]) * (2*C)'(bc[g]);
            r_ba1[g] <= ba[g];
        end
    end

    // ---------------- stage 2: normals, squared bond length
    logic signed [WN-1:0] r_n1 [3];
    logic signed [WN-1:0] r_n2 [3];
    logic signed [C-1:0]  r_ba2 [3];
    logic [SW-1:0]        r_sq;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_n1[i]  <= WN'(r_p1a[i]) - WN'(r_p1b[i]);
            r_n2[i]  <= WN'(r_p2a[i]) - WN'(r_p2b[i]);
            r_ba2[i] <= r_ba1[i];
        end
        r_sq <= SW'(unsigned'(r_sqp[0])) + SW'(unsigned'(r_sqp[1]))
              + SW'(unsigned'(r_sqp[2]));
    end

    // ---------------- stage 3: degenerate geometry
    logic r_deg;

    always_ff @(posedge i_clk) begin
        r_deg <= (r_sq == '0)
              || ((r_n1[0] == '0) && (r_n1[1] == '0) && (r_n1[2] == '0))
              || ((r_n2[0] == '0) && (r_n2[1] == '0) && (r_n2[2] == '0));
    end

    // ---------------- dot products, ready at stage 6
    logic signed [2*WN-1:0] xd_p [3];
    logic signed [C+WN-1:0] td_p [3];
    logic signed [WXD-1:0]  r_xd;
    logic signed [WTD-1:0]  r_td;

    for (genvar g = 0; g < 3; g++) begin : g_dot
        dafx_mul #(.WA(WN), .WB(WN)) u_mul_xd (
            .i_clk (i_clk),
            .i_a   (r_n1[g]),
            .i_b   (r_n2[g]),
            .o_p   (xd_p[g])
        );
        dafx_mul #(.WA(C), .WB(WN)) u_mul_td (
            .i_clk (i_clk),
            .i_a   (r_ba2[g]),
            .i_b   (r_n2[g]),
            .o_p   (td_p[g])
        );
    end

    always_ff @(posedge i_clk) begin
        r_xd <= WXD'(xd_p[0]) + WXD'(xd_p[1]) + WXD'(xd_p[2]);
        r_td <= WTD'(td_p[0]) + WTD'(td_p[1]) + WTD'(td_p[2]);
    end

    // ---------------- length normalizer: even left shift into [2^62, 2^64)
    logic [SW-1:0] r_sqn [NRM];
    logic [KB-1:0] r_kn  [NRM];

    for (genvar s = 0; s < NRM; s++) begin : g_lnorm
        localparam int J  = NRM - 1 - s;
        localparam int SH = 2 << J;
        logic [SW-1:0] sq_in;
        logic [KB-1:0] k_in;
        if (s == 0) begin : g_first
            assign sq_in = r_sq;
            assign k_in  = '0;
        end else begin : g_next
            assign sq_in = r_sqn[s-1];
            assign k_in  = r_kn[s-1];
        end
        always_ff @(posedge i_clk) begin
            if (sq_in[SW-1 -: SH] == '0) begin
                r_sqn[s] <= sq_in << SH;
                r_kn[s]  <= k_in | KB'(1 << J);
            end else begin
                r_sqn[s] <= sq_in;
                r_kn[s]  <= k_in;
            end
        end
    end

    // ---------------- square root chain, root ready at stage 39
    logic [SW-1:0] sq_op  [RB+1];
    logic [SW-1:0] sq_res [RB+1];

    assign sq_op[0]  = r_sqn[NRM-1];
    assign sq_res[0] = '0;

    for (genvar s = 0; s < RB; s++) begin : g_sqrt
        dafx_sqrt_cell #(.STEP(s)) u_cell (
            .i_clk (i_clk),
            .i_op  (sq_op[s]),
            .i_res (sq_res[s]),
            .o_op  (sq_op[s+1]),
            .o_res (sq_res[s+1])
        );
    end

    // ---------------- CORDIC operands
    logic [WTD-1:0]       td_d;
    logic [WXD-1:0]       xd_d;
    logic [KB-1:0]        k_d;
    logic signed [WY-1:0] y_p;
    logic signed [WX-1:0] r_x;
    logic [WX-1:0]        x_d;

    dafx_dly #(.W(WTD), .D(33)) u_dly_td (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_d (r_td), .o_q (td_d)
    );
    dafx_dly #(.W(WXD), .D(33)) u_dly_xd (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_d (r_xd), .o_q (xd_d)
    );
    dafx_dly #(.W(KB), .D(32)) u_dly_k (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_d (r_kn[NRM-1]), .o_q (k_d)
    );

    dafx_mul #(.WA(RB+1), .WB(WTD)) u_mul_y (
        .i_clk (i_clk),
        .i_a   ({1'b0, sq_res[RB][RB-1:0]}),
        .i_b   (signed'(td_d)),
        .o_p   (y_p)
    );

    always_ff @(posedge i_clk) begin
        r_x <= WX'(signed'(xd_d)) <<< k_d;
    end

    dafx_dly #(.W(WX), .D(2)) u_dly_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_d (r_x), .o_q (x_d)
    );

    // ---------------- operand normalizer: larger magnitude down to OP_BITS
    logic signed [WM-1:0] xw;
    logic signed [WM-1:0] yw;
    logic signed [WM-1:0] r_xa;
    logic signed [WM-1:0] r_ya;
    logic [WM-1:0]        r_ma;

    assign xw = WM'(signed'(x_d));
    assign yw = WM'(y_p);

    always_ff @(posedge i_clk) begin
        r_xa <= xw;
        r_ya <= yw;
        // OR of magnitudes has the bit count of the larger one
        r_ma <= (xw[WM-1] ? unsigned'(-xw) : unsigned'(xw))
              | (yw[WM-1] ? unsigned'(-yw) : unsigned'(yw));
    end

    logic signed [WM-1:0] r_xs [NJ];
    logic signed [WM-1:0] r_ys [NJ];
    logic [WM-1:0]        r_ms [NJ];

    for (genvar s = 0; s < NJ; s++) begin : g_onorm
        localparam int J  = NJ - 1 - s;
        localparam int SH = 1 << J;
        logic signed [WM-1:0] x_in;
        logic signed [WM-1:0] y_in;
        logic [WM-1:0]        m_in;
        if (s == 0) begin : g_first
            assign x_in = r_xa;
            assign y_in = r_ya;
            assign m_in = r_ma;
        end else begin : g_next
            assign x_in = r_xs[s-1];
            assign y_in = r_ys[s-1];
            assign m_in = r_ms[s-1];
        end
        always_ff @(posedge i_clk) begin
            if ((m_in >> (dafx_pkg::OP_BITS - 1 + SH)) != '0) begin
                r_xs[s] <= x_in >>> SH;
                r_ys[s] <= y_in >>> SH;
                r_ms[s] <= m_in >> SH;
            end else begin
                r_xs[s] <= x_in;
                r_ys[s] <= y_in;
                r_ms[s] <= m_in;
            end
        end
    end

    // ---------------- quadrant pre-rotation for negative x
    logic signed [CB-1:0] xo;
    logic signed [CB-1:0] yo;
    logic signed [CB-1:0] cx [NCS+1];
    logic signed [CB-1:0] cy [NCS+1];
    logic signed [CB-1:0] cz [NCS+1];
    logic signed [CB-1:0] r_px;
    logic signed [CB-1:0] r_py;
    logic signed [CB-1:0] r_pz;

    assign xo = CB'(r_xs[NJ-1]);
    assign yo = CB'(r_ys[NJ-1]);

    always_ff @(posedge i_clk) begin
        if (!xo[CB-1]) begin
            r_px <= xo;
            r_py <= yo;
            r_pz <= '0;
        end else if (!yo[CB-1]) begin
            r_px <= yo;
            r_py <= -xo;
            r_pz <= CB'(1) <<< 30;
        end else begin
            r_px <= -yo;
            r_py <= xo;
            r_pz <= -(CB'(1) <<< 30);
        end
    end

    assign cx[0] = r_px;
    assign cy[0] = r_py;
    assign cz[0] = r_pz;

    for (genvar s = 0; s < NCS; s++) begin : g_cordic
        dafx_cordic_cell #(.STEP(s)) u_cell (
            .i_clk (i_clk),
            .i_x   (cx[s]),
            .i_y   (cy[s]),
            .i_z   (cz[s]),
            .o_x   (cx[s+1]),
            .o_y   (cy[s+1]),
            .o_z   (cz[s+1])
        );
    end

    // ---------------- control and result
    logic                 vld_d;
    logic                 deg_d;
    logic signed [CB-1:0] z_rnd;

    dafx_dly #(.W(1), .D(LAT)) u_dly_vld (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_d (start), .o_q (vld_d)
    );
    dafx_dly #(.W(1), .D(LAT - 3)) u_dly_deg (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_d (r_deg), .o_q (deg_d)
    );

    // round to nearest; bits above the angle field wrap away
    assign z_rnd = cz[NCS] + (CB'(1) <<< (31 - AB));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= vld_d;
        end
        o_result.angle       <= deg_d ? '0 : z_rnd[31 -: AB];
        o_result.angle_valid <= !deg_d;
    end

endmodule

/* sv/dafx_dly.sv */
module dafx_dly #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_tap [D];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < D; i++) begin
                r_tap[i] <= '0;
            end
        end else begin
            r_tap[0] <= i_d;
            for (int i = 1; i < D; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    assign o_q = r_tap[D-1];

endmodule

/* sv/dafx_mul.sv */
// Signed multiplier, registered in turn: limb products, row sums, final sum.
module dafx_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic                     i_clk,
    input  logic signed [WA-1:0]     i_a,
    input  logic signed [WB-1:0]     i_b,
    output logic signed [WA+WB-1:0]  o_p
);

    localparam int LW = dafx_pkg::LIMB_BITS;
    localparam int NA = (WA + LW - 1) / LW;
    localparam int NB = (WB + LW - 1) / LW;
    localparam int WP = WA + WB;

    logic signed [NA*LW-1:0]  a_ext;
    logic signed [NB*LW-1:0]  b_ext;
    logic signed [LW:0]       a_limb [NA];
    logic signed [LW:0]       b_limb [NB];
    logic signed [2*LW+1:0]   r_pp   [NA][NB];
    logic signed [WP-1:0]     n_row  [NA];
    logic signed [WP-1:0]     r_row  [NA];
    logic signed [WP-1:0]     n_p;
    logic signed [WP-1:0]     r_p;

    assign a_ext = (NA*LW)'(i_a);
    assign b_ext = (NB*LW)'(i_b);

    // low limbs unsigned, top limb carries the sign
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            if (i == NA - 1) begin
                a_limb[i] = {a_ext[NA*LW-1], a_ext[i*LW +: LW]};
            end else begin
                a_limb[i] = {1'b0, a_ext[i*LW +: LW]};
            end
        end
        for (int j = 0; j < NB; j++) begin
            if (j == NB - 1) begin
                b_limb[j] = {b_ext[NB*LW-1], b_ext[j*LW +: LW]};
            end else begin
                b_limb[j] = {1'b0, b_ext[j*LW +: LW]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                r_pp[i][j] <= (2*LW+2)'(a_limb[i]) * (2*LW+2)'(b_limb[j]);
            end
        end
    end

    // sums wrap modulo 2^WP; the exact product fits
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (WP'(r_pp[i][j]) <<< (LW*j));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
    end

    always_comb begin
        n_p = '0;
        for (int i = 0; i < NA; i++) begin
            n_p = n_p + (r_row[i] <<< (LW*i));
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

/* sv/dafx_sqrt_cell.sv */
// One step of the bitwise square root; STEP picks the trial bit.
module dafx_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                             i_clk,
    input  logic [dafx_pkg::SQ_BITS-1:0]     i_op,
    input  logic [dafx_pkg::SQ_BITS-1:0]     i_res,
    output logic [dafx_pkg::SQ_BITS-1:0]     o_op,
    output logic [dafx_pkg::SQ_BITS-1:0]     o_res
);

    localparam int SW = dafx_pkg::SQ_BITS;
    localparam logic [SW-1:0] TRIAL = SW'(1) << (SW - 2 - 2*STEP);

    logic [SW:0]   trial_sum;
    logic [SW-1:0] n_op;
    logic [SW-1:0] n_res;
    logic [SW-1:0] r_op;
    logic [SW-1:0] r_res;

    always_comb begin
        trial_sum = {1'b0, i_res} + {1'b0, TRIAL};
        if ({1'b0, i_op} >= trial_sum) begin
            n_op  = i_op - trial_sum[SW-1:0];
            n_res = (i_res >> 1) + TRIAL;
        end else begin
            n_op  = i_op;
            n_res = i_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_res <= n_res;
    end

    assign o_op  = r_op;
    assign o_res = r_res;

endmodule

/* sv/dafx_cordic_cell.sv */
// One vectoring CORDIC iteration; drives y toward zero.
module dafx_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                                    i_clk,
    input  logic signed [dafx_pkg::CORDIC_BITS-1:0] i_x,
    input  logic signed [dafx_pkg::CORDIC_BITS-1:0] i_y,
    input  logic signed [dafx_pkg::CORDIC_BITS-1:0] i_z,
    output logic signed [dafx_pkg::CORDIC_BITS-1:0] o_x,
    output logic signed [dafx_pkg::CORDIC_BITS-1:0] o_y,
    output logic signed [dafx_pkg::CORDIC_BITS-1:0] o_z
);

    localparam int CB = dafx_pkg::CORDIC_BITS;
    localparam logic signed [CB-1:0] ANG = CB'(dafx_pkg::ATAN_TAB[STEP]);

    logic signed [CB-1:0] dx;
    logic signed [CB-1:0] dy;
    logic signed [CB-1:0] r_x;
    logic signed [CB-1:0] r_y;
    logic signed [CB-1:0] r_z;

    assign dx = i_y >>> STEP;
    assign dy = i_x >>> STEP;

    always_ff @(posedge i_clk) begin
        if (!i_y[CB-1]) begin
            r_x <= i_x + dx;
            r_y <= i_y - dy;
            r_z <= i_z + ANG;
        end else begin
            r_x <= i_x - dx;
            r_y <= i_y + dy;
            r_z <= i_z - ANG;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

/* bench/tb_dihedral_angle_fixed_core.sv */
module tb_dihedral_angle_fixed_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 82;
    localparam int CYC_LIMIT = 400000;

    typedef logic signed [191:0] t_wide;

    class angle_scoreboard;
        dafx_pkg::t_result want_q[$];
        int                errors;

        function new();
            errors = 0;
        endfunction

        static function int mag_bits(t_wide v);
            t_wide m;
            m = (v < 0) ? -v : v;
            for (int i = 191; i >= 0; i--) begin
                if (m[i]) return i + 1;
            end
            return 0;
        endfunction

        static function dafx_pkg::t_result torsion(dafx_pkg::t_item it);
            t_wide   a[3], b[3], c[3], nb[3], n1[3], n2[3];
            t_wide   xd, td, xw, yw, rw;
            logic [63:0] sq, op, bt, res;
            longint  x, y, z, t, dx, dy;
            int      k, lx, ly, s;
            dafx_pkg::t_result o;
            a[0] = it.ba_x; a[1] = it.ba_y; a[2] = it.ba_z;
            b[0] = it.bc_x; b[1] = it.bc_y; b[2] = it.bc_z;
            c[0] = it.cd_x; c[1] = it.cd_y; c[2] = it.cd_z;
            sq = 0;
            for (int i = 0; i < 3; i++) begin
                nb[i] = -a[i];
                sq += 64'(b[i] * b[i]);
            end
            n1[0] = nb[1] * b[2] - nb[2] * b[1];
            n1[1] = nb[2] * b[0] - nb[0] * b[2];
            n1[2] = nb[0] * b[1] - nb[1] * b[0];
            n2[0] = b[1] * c[2] - b[2] * c[1];
            n2[1] = b[2] * c[0] - b[0] * c[2];
            n2[2] = b[0] * c[1] - b[1] * c[0];
            o.angle = '0;
            o.angle_valid = 1'b0;
            if (sq == 0 || (n1[0] == 0 && n1[1] == 0 && n1[2] == 0) ||
                (n2[0] == 0 && n2[1] == 0 && n2[2] == 0))
                return o;
            xd = n1[0] * n2[0] + n1[1] * n2[1] + n1[2] * n2[2];
            td = a[0] * n2[0] + a[1] * n2[1] + a[2] * n2[2];
            k = 0;
            while (sq < (64'd1 << 62)) begin
                sq = sq << 2;
                k++;
            end
            // bitwise floor square root
            op = sq; res = 0; bt = 64'd1 << 62;
            while (bt > op) bt = bt >> 2;
            while (bt != 0) begin
                if (op >= res + bt) begin
                    op = op - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
            rw = {128'b0, res};
            yw = rw * td;
            xw = xd <<< k;
            lx = mag_bits(xw);
            ly = mag_bits(yw);
            if (ly > lx) lx = ly;
            s = (lx > dafx_pkg::OP_BITS) ? lx - dafx_pkg::OP_BITS : 0;
            x = 64'(xw >>> s);
            y = 64'(yw >>> s);
            z = 0;
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y; y = -t; z = 64'sd1 <<< 30;
                end else begin
                    x = -y; y = t; z = -(64'sd1 <<< 30);
                end
            end
            for (int i = 0; i < dafx_pkg::CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += $signed({32'b0, dafx_pkg::ATAN_TAB[i]});
                end else begin
                    x -= dx; y += dy; z -= $signed({32'b0, dafx_pkg::ATAN_TAB[i]});
                end
            end
            z = (z + (64'sd1 <<< (31 - dafx_pkg::ANGLE_BITS))) >>> (32 - dafx_pkg::ANGLE_BITS);
            o.angle = dafx_pkg::ANGLE_BITS'(z);
            o.angle_valid = 1'b1;
            return o;
        endfunction

        function void note_item(dafx_pkg::t_item it);
            want_q = {want_q, torsion(it)};
        endfunction

        function void check_result(dafx_pkg::t_result got);
            dafx_pkg::t_result w;
            if (want_q.size() == 0) begin
                $display("%0t: unexpected result angle=%0d valid=%0b",
                         $time, got.angle, got.angle_valid);
                errors++;
                return;
            end
            w = want_q.pop_front();
            if (got.angle !== w.angle) begin
                $display("%0t: angle mismatch expected %0d actual %0d",
                         $time, w.angle, got.angle);
                errors++;
            end
            if (got.angle_valid !== w.angle_valid) begin
                $display("%0t: angle_valid mismatch expected %0b actual %0b",
                         $time, w.angle_valid, got.angle_valid);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    dafx_pkg::t_item   i_item;
    logic              o_strobe;
    dafx_pkg::t_result o_result;

    angle_scoreboard sb = new();
    bit      took;
    int      cycles;
    int      idle_pct;

    dihedral_angle_fixed_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (i_rst_n && start && !busy) begin
            sb.note_item(i_item);
            took = 1'b1;
        end
        if (i_rst_n && o_strobe) sb.check_result(o_result);
    end

    task automatic send_item(dafx_pkg::t_item it);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        took = 1'b0;
        start  <= 1'b1;
        i_item <= it;
        do @(negedge i_clk); while (!took);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.want_q.size() != 0) @(negedge i_clk);
    endtask

    function automatic dafx_pkg::t_item make_item(int unsigned shp);
        dafx_pkg::t_item it;
        logic [dafx_pkg::COORD_BITS-1:0] v[9];
        int sh;
        sh = $urandom_range(dafx_pkg::COORD_BITS - 1);
        for (int i = 0; i < 9; i++) begin
            v[i] = dafx_pkg::COORD_BITS'($urandom);
            case (shp)
                1: v[i] = dafx_pkg::COORD_BITS'($signed($urandom_range(6)) - 3);
                2: v[i] = dafx_pkg::COORD_BITS'($signed(v[i]) >>> sh);
                default: ;
            endcase
        end
        it = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
        // occasionally force BA collinear with BC
        if (shp == 3) begin
            it.bc_x[0] = 1'b0; it.bc_y[0] = 1'b0; it.bc_z[0] = 1'b0;
            it.ba_x = it.bc_x >>> 1; it.ba_y = it.bc_y >>> 1; it.ba_z = it.bc_z >>> 1;
        end
        return it;
    endfunction

    function automatic dafx_pkg::t_item vec3(int ax, int ay, int az, int bx, int by, int bz,
                                             int cx, int cy, int cz);
        dafx_pkg::t_item it;
        it.ba_x = dafx_pkg::COORD_BITS'(ax);
        it.ba_y = dafx_pkg::COORD_BITS'(ay);
        it.ba_z = dafx_pkg::COORD_BITS'(az);
        it.bc_x = dafx_pkg::COORD_BITS'(bx);
        it.bc_y = dafx_pkg::COORD_BITS'(by);
        it.bc_z = dafx_pkg::COORD_BITS'(bz);
        it.cd_x = dafx_pkg::COORD_BITS'(cx);
        it.cd_y = dafx_pkg::COORD_BITS'(cy);
        it.cd_z = dafx_pkg::COORD_BITS'(cz);
        return it;
    endfunction

    initial begin
        int mx, mn, one;
        mx = 8388607; mn = -8388608; one = 4096;
        cycles   = 0;
        idle_pct = 0;
        took     = 1'b0;
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_item   = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item(vec3(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(vec3(one, 0, 0, 0, 0, 0, 0, one, 0));          // zero bond
        send_item(vec3(2*one, 0, 0, one, 0, 0, 0, one, 0));      // BA along BC
        send_item(vec3(0, one, 0, one, 0, 0, 3*one, 0, 0));      // CD along BC
        send_item(vec3(0, one, 0, one, 0, 0, 0, one, 0));        // zero torsion
        send_item(vec3(0, one, 0, one, 0, 0, 0, -one, 0));       // straight angle
        send_item(vec3(0, one, 0, one, 0, 0, 0, 0, one));
        send_item(vec3(0, one, 0, one, 0, 0, 0, 0, -one));
        send_item(vec3(0, one, 0, one, 0, 0, 0, -one, 1));
        send_item(vec3(0, one, 0, one, 0, 0, 0, -one, -1));
        send_item(vec3(mx, mx, mx, mx, mx, mx, mx, mx, mx));
        send_item(vec3(mn, mn, mn, mn, mn, mn, mn, mn, mn));
        send_item(vec3(mx, mn, 0, mn, mx, mx, mx, mn, mn));
        send_item(vec3(mn, 0, mx, 0, mn, 0, mx, mx, mn));
        send_item(vec3(mn, 0, 0, 0, mn, 0, 0, 0, mn));
        send_item(vec3(mx, 0, 0, 0, 0, mx, mn, mx, 0));
        send_item(vec3(1, 0, 0, 0, 1, 0, 0, 0, 1));
        send_item(vec3(-1, 0, 0, 0, 1, 0, 0, 0, -1));
        send_item(vec3(1, 2, 3, -3, 1, 2, 2, -3, 1));
        send_item(vec3(mx, -1, 1, 1, mx, -1, -1, 1, mx));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: idle_pct = 0;
                1: idle_pct = 50;
                2: idle_pct = 0;
                default: idle_pct = 21;
            endcase
            for (int n = 0; n < 450; n++) begin
                int unsigned r;
                r = $urandom_range(99);
                send_item(make_item(r < 55 ? 0 : r < 80 ? 2 : r < 92 ? 1 : 3));
            end
            drain();
        end

        repeat (LATENCY + 20) @(negedge i_clk);
        if (sb.errors == 0 && sb.want_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

/* files.f */
sv/dafx_pkg.sv
sv/dafx_dly.sv
sv/dafx_mul.sv
sv/dafx_sqrt_cell.sv
sv/dafx_cordic_cell.sv
sv/dihedral_angle_fixed_core.sv
bench/tb_dihedral_angle_fixed_core.sv
